// ===== sv/nrmc_pkg.sv =====
// Shared types, character codes and constants of the RMC position parser.
package nrmc_pkg;

  // Default number of minute-fraction digits kept by the converter.
  localparam int FRAC_DIGITS = 5;

  // Fields past the last one are not split any further.
  localparam int FIELD_COUNT = 12;
  localparam logic [3:0] FIELD_LAST = 4'(FIELD_COUNT - 1);

  localparam logic [3:0] FLD_STATUS   = 4'd2;
  localparam logic [3:0] FLD_LAT      = 4'd3;
  localparam logic [3:0] FLD_LAT_HEMI = 4'd4;
  localparam logic [3:0] FLD_LON      = 4'd5;
  localparam logic [3:0] FLD_LON_HEMI = 4'd6;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  // Sentence prefix "$GNRMC"; the third byte may also be 'P'.
  localparam int PREFIX_CHARS = 6;
  localparam logic [2:0] PREFIX_ALT_POS = 3'd2;
  localparam logic [7:0] PREFIX_TEXT [PREFIX_CHARS] =
    '{8'h24, 8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43};

  // Whole degrees are the integer part divided by 100, saturated at 999.
  localparam int DEG_W = 10;
  localparam logic [DEG_W-1:0] DEG_SAT = 10'd999;

  localparam longint unsigned E7 = 64'd10000000;

  // Minute contribution in degrees times 1e7 stays below 16.67e6.
  localparam int MINPART_W = 24;
  // Magnitude of a coordinate and the signed stored value.
  localparam int MAG_W = 34;
  localparam int POS_W = 35;

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_A,
    ST_OTHER
  } status_t;

  // Per-byte control of one coordinate accumulator.
  typedef struct packed {
    logic clear;
    logic num_en;
    logic hemi_en;
  } coord_ctl_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    r = 64'd1;
    for (int i = 0; i < n; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

endpackage

// ===== sv/nrmc_if.sv =====
// Valid/ready channels for received bytes and for parsed fix results.
interface nrmc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_fix_if import nrmc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    fix_valid;
  logic                    position_updated;
  logic signed [POS_W-1:0] latitude_e7;
  logic signed [POS_W-1:0] longitude_e7;

  modport source (output valid, output fix_valid, output position_updated,
                  output latitude_e7, output longitude_e7, input ready);
  modport sink (input valid, input fix_valid, input position_updated,
                input latitude_e7, input longitude_e7, output ready);
endinterface

// ===== sv/nrmc_coord.sv =====
// Accumulates one ddmm.fffff coordinate field and its hemisphere flag.
module nrmc_coord import nrmc_pkg::*; #(
  parameter int FRACTION_DIGITS = FRAC_DIGITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  coord_ctl_t           ctl,
  input  logic [7:0]           ch,
  output logic [DEG_W-1:0]     degrees,
  output logic [$clog2(100 * pow10(FRACTION_DIGITS))-1:0] minutes,
  output logic                 negative,
  output logic                 short_field
);

  localparam longint unsigned Unit = pow10(FRACTION_DIGITS);
  localparam int MinW = $clog2(100 * Unit);
  localparam int FcW = $clog2(FRACTION_DIGITS + 1);
  localparam logic [MinW-1:0] SatMinutes = MinW'(99 * Unit);
  localparam logic [MinW-1:0] UnitW = MinW'(Unit);

  // Weight of the n-th digit after the point, in units of the last kept digit.
  function automatic logic [MinW-1:0] frac_weight(input logic [FcW-1:0] n);
    logic [MinW-1:0] w;
    w = '0;
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      if (n == FcW'(i)) begin
        w = MinW'(pow10(FRACTION_DIGITS - 1 - i));
      end
    end
    return w;
  endfunction

  logic [DEG_W-1:0] deg, deg_next;
  logic [3:0]       tens, tens_next;
  logic [3:0]       ones, ones_next;
  logic [MinW-1:0]  mins, mins_next;
  logic [FcW-1:0]   fcount, fcount_next;
  logic [2:0]       char_cnt, char_cnt_next;
  logic             point, point_next;
  logic             stop, stop_next;
  logic             neg, neg_next;

  logic             is_digit;
  logic [3:0]       digit;
  logic [13:0]      deg_wide;
  logic [6:0]       low_two;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit    = ch[3:0];
  // The integer part is kept as degrees plus two minute digits; shifting in
  // a digit moves the tens digit into the degrees.
  assign deg_wide = 14'(deg) * 14'd10 + 14'(tens);
  assign low_two  = 7'(ones) * 7'd10 + 7'(digit);

  always_comb begin
    deg_next      = deg;
    tens_next     = tens;
    ones_next     = ones;
    mins_next     = mins;
    fcount_next   = fcount;
    char_cnt_next = char_cnt;
    point_next    = point;
    stop_next     = stop;
    neg_next      = neg;
    if (ctl.clear) begin
      deg_next      = '0;
      tens_next     = '0;
      ones_next     = '0;
      mins_next     = '0;
      fcount_next   = '0;
      char_cnt_next = '0;
      point_next    = 1'b0;
      stop_next     = 1'b0;
      neg_next      = 1'b0;
    end else begin
      if (ctl.hemi_en) begin
        neg_next = (ch == CH_S) || (ch == CH_W);
      end
      if (ctl.num_en) begin
        if (char_cnt != 3'd4) begin
          char_cnt_next = char_cnt + 3'd1;
        end
        if (!stop) begin
          if (is_digit) begin
            if (!point) begin
              if (deg_wide > 14'(DEG_SAT)) begin
                deg_next  = DEG_SAT;
                tens_next = 4'd9;
                ones_next = 4'd9;
                mins_next = SatMinutes;
              end else begin
                deg_next  = deg_wide[DEG_W-1:0];
                tens_next = ones;
                ones_next = digit;
                mins_next = MinW'(MinW'(low_two) * UnitW);
              end
            end else if (fcount < FcW'(FRACTION_DIGITS)) begin
              mins_next   = mins + MinW'(frac_weight(fcount) * MinW'(digit));
              fcount_next = fcount + FcW'(1);
            end
          end else if (ch == CH_POINT && !point) begin
            point_next = 1'b1;
          end else begin
            stop_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deg      <= '0;
      tens     <= '0;
      ones     <= '0;
      mins     <= '0;
      fcount   <= '0;
      char_cnt <= '0;
      point    <= 1'b0;
      stop     <= 1'b0;
      neg      <= 1'b0;
    end else begin
      deg      <= deg_next;
      tens     <= tens_next;
      ones     <= ones_next;
      mins     <= mins_next;
      fcount   <= fcount_next;
      char_cnt <= char_cnt_next;
      point    <= point_next;
      stop     <= stop_next;
      neg      <= neg_next;
    end
  end

  assign degrees     = deg;
  assign minutes     = mins;
  assign negative    = neg;
  assign short_field = (char_cnt != 3'd4);

endmodule

// ===== sv/nmea_rmc_position_parser.sv =====
// Top level of the RMC sentence parser: line state, conversion and result register.
// Throughput: one received byte per cycle; the byte path only stalls when a
// converted result and a result in the output register both wait on the sink.
// A result passes from its newline transfer through the product register, then
// the output register that also updates the stored position, before it is offered.
// Reset (rst, synchronous): clears the line state and both stored coordinates
// to zero; no result is pending afterwards.
module nmea_rmc_position_parser import nrmc_pkg::*; #(
  parameter int FRACTION_DIGITS = FRAC_DIGITS
) (
  input logic        clk,
  input logic        rst,
  nrmc_byte_if.sink  rx,
  nrmc_fix_if.source result
);

  localparam longint unsigned Unit = pow10(FRACTION_DIGITS);
  localparam int MinW = $clog2(100 * Unit);
  // floor(m * 1e7 / (60 * Unit)) as a multiply by a rounded-up reciprocal.
  localparam longint unsigned Divisor = 60 * Unit;
  localparam int Shift = $clog2(6000 * Unit) + 1;
  localparam logic [31:0] Recip = 32'(((E7 << Shift) + Divisor - 1) / Divisor);
  localparam int ProdW = MinW + 32;

  // Line state.
  logic [2:0] prefix_pos, prefix_pos_next;
  logic       prefix_ok, prefix_ok_next;
  logic [3:0] field_num, field_num_next;
  status_t    status, status_next;
  logic [3:0] nonempty, nonempty_next;

  coord_ctl_t lat_ctl, lon_ctl;
  logic [DEG_W-1:0] lat_deg, lon_deg;
  logic [MinW-1:0]  lat_min, lon_min;
  logic             lat_neg, lon_neg;
  logic             lat_short, lon_short;

  logic       accept;
  logic       is_lf;
  logic       is_rmc;
  logic       load;
  logic [7:0] ch;

  // Product register.
  logic                 p_valid;
  logic                 p_fix, p_upd;
  logic [MAG_W-1:0]     p_lat_deg, p_lon_deg;
  logic [MINPART_W-1:0] p_lat_min, p_lon_min;
  logic                 p_lat_neg, p_lon_neg, p_lat_short, p_lon_short;
  logic                 p_move;

  // Output register and stored position.
  logic                    o_valid;
  logic                    o_fix, o_upd;
  logic signed [POS_W-1:0] o_lat, o_lon;
  logic signed [POS_W-1:0] lat_store, lon_store;
  logic [MAG_W-1:0]        lat_mag, lon_mag;
  logic signed [POS_W-1:0] lat_val, lon_val;
  logic [ProdW-1:0]        lat_prod, lon_prod;

  assign ch     = rx.rx_byte;
  assign p_move = p_valid && (!o_valid || result.ready);
  assign rx.ready = !p_valid || p_move;
  assign accept = rx.valid && rx.ready;
  assign is_lf  = (ch == CH_LF);
  assign is_rmc = prefix_ok && (prefix_pos == 3'(PREFIX_CHARS));
  assign load   = accept && is_lf && is_rmc;

  always_comb begin
    prefix_pos_next = prefix_pos;
    prefix_ok_next  = prefix_ok;
    field_num_next  = field_num;
    status_next     = status;
    nonempty_next   = nonempty;
    lat_ctl         = '0;
    lon_ctl         = '0;
    if (accept) begin
      if (is_lf) begin
        prefix_pos_next = '0;
        prefix_ok_next  = 1'b1;
        field_num_next  = '0;
        status_next     = ST_EMPTY;
        nonempty_next   = '0;
        lat_ctl.clear   = 1'b1;
        lon_ctl.clear   = 1'b1;
      end else begin
        if (prefix_pos != 3'(PREFIX_CHARS)) begin
          if (!(ch == PREFIX_TEXT[prefix_pos] ||
                (prefix_pos == PREFIX_ALT_POS && ch == CH_P))) begin
            prefix_ok_next = 1'b0;
          end
          prefix_pos_next = prefix_pos + 3'd1;
        end
        if (ch == CH_COMMA) begin
          if (field_num != FIELD_LAST) begin
            field_num_next = field_num + 4'd1;
          end
        end else begin
          unique case (field_num)
            FLD_STATUS: begin
              status_next = (status == ST_EMPTY && ch == CH_A) ? ST_A : ST_OTHER;
            end
            FLD_LAT: begin
              lat_ctl.num_en   = 1'b1;
              nonempty_next[0] = 1'b1;
            end
            FLD_LAT_HEMI: begin
              // Only the first byte of a hemisphere field counts.
              lat_ctl.hemi_en  = !nonempty[1];
              nonempty_next[1] = 1'b1;
            end
            FLD_LON: begin
              lon_ctl.num_en   = 1'b1;
              nonempty_next[2] = 1'b1;
            end
            FLD_LON_HEMI: begin
              lon_ctl.hemi_en  = !nonempty[3];
              nonempty_next[3] = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pos <= '0;
      prefix_ok  <= 1'b1;
      field_num  <= '0;
      status     <= ST_EMPTY;
      nonempty   <= '0;
    end else begin
      prefix_pos <= prefix_pos_next;
      prefix_ok  <= prefix_ok_next;
      field_num  <= field_num_next;
      status     <= status_next;
      nonempty   <= nonempty_next;
    end
  end

  nrmc_coord #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_lat (
    .clk         (clk),
    .rst         (rst),
    .ctl         (lat_ctl),
    .ch          (ch),
    .degrees     (lat_deg),
    .minutes     (lat_min),
    .negative    (lat_neg),
    .short_field (lat_short)
  );

  nrmc_coord #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_lon (
    .clk         (clk),
    .rst         (rst),
    .ctl         (lon_ctl),
    .ch          (ch),
    .degrees     (lon_deg),
    .minutes     (lon_min),
    .negative    (lon_neg),
    .short_field (lon_short)
  );

  assign lat_prod = ProdW'(lat_min) * ProdW'(Recip);
  assign lon_prod = ProdW'(lon_min) * ProdW'(Recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (load) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_fix       <= (status == ST_A);
      p_upd       <= (status == ST_A) && (nonempty == 4'hF);
      p_lat_deg   <= MAG_W'(lat_deg) * MAG_W'(E7);
      p_lon_deg   <= MAG_W'(lon_deg) * MAG_W'(E7);
      p_lat_min   <= lat_prod[Shift +: MINPART_W];
      p_lon_min   <= lon_prod[Shift +: MINPART_W];
      p_lat_neg   <= lat_neg;
      p_lon_neg   <= lon_neg;
      p_lat_short <= lat_short;
      p_lon_short <= lon_short;
    end
  end

  assign lat_mag = p_lat_deg + MAG_W'(p_lat_min);
  assign lon_mag = p_lon_deg + MAG_W'(p_lon_min);

  always_comb begin
    if (p_lat_short) begin
      lat_val = '0;
    end else if (p_lat_neg) begin
      lat_val = -$signed({1'b0, lat_mag});
    end else begin
      lat_val = $signed({1'b0, lat_mag});
    end
    if (p_lon_short) begin
      lon_val = '0;
    end else if (p_lon_neg) begin
      lon_val = -$signed({1'b0, lon_mag});
    end else begin
      lon_val = $signed({1'b0, lon_mag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid   <= 1'b0;
      lat_store <= '0;
      lon_store <= '0;
    end else begin
      if (p_move) begin
        o_valid <= 1'b1;
        if (p_upd) begin
          lat_store <= lat_val;
          lon_store <= lon_val;
        end
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_fix <= p_fix;
      o_upd <= p_upd;
      o_lat <= p_upd ? lat_val : lat_store;
      o_lon <= p_upd ? lon_val : lon_store;
    end
  end

  assign result.valid            = o_valid;
  assign result.fix_valid        = o_fix;
  assign result.position_updated = o_upd;
  assign result.latitude_e7      = o_lat;
  assign result.longitude_e7     = o_lon;

  // The byte path only stalls behind a pending converted result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> p_valid && o_valid && !result.ready)
    else $error("byte path stalled without a blocked result");

  // A result that leaves the product register is offered in the next cycle.
  a_move_offer: assert property (@(posedge clk) disable iff (rst)
    p_move |=> result.valid)
    else $error("moved result was not offered");

  // An update is only reported together with a valid fix.
  a_upd_fix: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!result.position_updated || result.fix_valid))
    else $error("position update without a valid fix");

  // A result without an update carries the stored position unchanged.
  a_hold_store: assert property (@(posedge clk) disable iff (rst)
    p_move && !p_upd |=> result.latitude_e7 == lat_store &&
                         result.longitude_e7 == lon_store)
    else $error("stored position changed without an update");

  a_prefix_range: assert property (@(posedge clk) disable iff (rst)
    prefix_pos <= 3'(PREFIX_CHARS))
    else $error("prefix position ran past the prefix");

endmodule

// ===== bench/nrmc_fix_checker.sv =====
// Checker for the RMC parser: predicts each parsed result and compares it with the output.
`timescale 1ns / 1ps

module nrmc_fix_checker import nrmc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  nrmc_byte_if  rx,
  nrmc_fix_if   result,
  output int    errors,
  output int    pending
);

  localparam int unsigned INT_PART_MAX = 99999;

  typedef struct {
    logic                    fix;
    logic                    upd;
    logic signed [POS_W-1:0] lat;
    logic signed [POS_W-1:0] lon;
  } fix_result_t;

  fix_result_t fix_expect_q[$];

  // Line state of the parser as seen from the byte stream.
  logic [2:0] pfx_pos;
  logic       pfx_ok;
  logic [3:0] fld;
  status_t    status;
  logic [3:0] present;

  // Per coordinate: index 0 is latitude, 1 is longitude.
  int unsigned c_int[2];
  int unsigned c_frac[2];
  int          c_fcnt[2];
  int          c_chars[2];
  bit          c_point[2];
  bit          c_stop[2];
  bit          c_neg[2];
  logic signed [POS_W-1:0] pos_store[2];

  int fail_count;

  function automatic void clear_line_state();
    pfx_pos = '0;
    pfx_ok  = 1'b1;
    fld     = '0;
    status  = ST_EMPTY;
    present = '0;
    for (int k = 0; k < 2; k++) begin
      c_int[k]   = 0;
      c_frac[k]  = 0;
      c_fcnt[k]  = 0;
      c_chars[k] = 0;
      c_point[k] = 1'b0;
      c_stop[k]  = 1'b0;
      c_neg[k]   = 1'b0;
    end
  endfunction

  function automatic void coord_char(input int k, input logic [7:0] ch);
    int unsigned grown;
    if (c_chars[k] < 4) c_chars[k]++;
    if (c_stop[k]) return;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (!c_point[k]) begin
        grown = c_int[k] * 10 + (ch - CH_ZERO);
        c_int[k] = (grown > INT_PART_MAX) ? INT_PART_MAX : grown;
      end else if (c_fcnt[k] < FRAC_DIGITS) begin
        c_frac[k] = c_frac[k] * 10 + (ch - CH_ZERO);
        c_fcnt[k]++;
      end
    end else if (ch == CH_POINT && !c_point[k]) begin
      c_point[k] = 1'b1;
    end else begin
      // Anything else ends the number; later bytes still count toward the length.
      c_stop[k] = 1'b1;
    end
  endfunction

  function automatic logic signed [POS_W-1:0] coord_to_e7(input int k);
    longint unsigned unit_scale;
    longint unsigned frac;
    longint unsigned minutes;
    longint unsigned mag;
    if (c_chars[k] < 4) return '0;
    unit_scale = 1;
    frac = c_frac[k];
    for (int i = 0; i < FRAC_DIGITS; i++) unit_scale = unit_scale * 10;
    for (int i = c_fcnt[k]; i < FRAC_DIGITS; i++) frac = frac * 10;
    minutes = (c_int[k] % 100) * unit_scale + frac;
    mag = (c_int[k] / 100) * E7 + (minutes * E7) / (60 * unit_scale);
    return c_neg[k] ? -POS_W'(mag) : POS_W'(mag);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] ch);
    fix_result_t want;
    int          slot;
    if (ch == CH_LF) begin
      if (pfx_ok && pfx_pos == 3'(PREFIX_CHARS)) begin
        want.fix = (status == ST_A);
        want.upd = want.fix && (&present);
        if (want.upd) begin
          pos_store[0] = coord_to_e7(0);
          pos_store[1] = coord_to_e7(1);
        end
        want.lat = pos_store[0];
        want.lon = pos_store[1];
        fix_expect_q.push_back(want);
      end
      clear_line_state();
      return;
    end
    if (pfx_pos < PREFIX_CHARS) begin
      if (!(ch == PREFIX_TEXT[pfx_pos] || (pfx_pos == PREFIX_ALT_POS && ch == CH_P)))
        pfx_ok = 1'b0;
      pfx_pos++;
    end
    if (ch == CH_COMMA) begin
      if (fld != FIELD_LAST) fld++;
    end else if (fld == FLD_STATUS) begin
      status = (status == ST_EMPTY && ch == CH_A) ? ST_A : ST_OTHER;
    end else if (fld >= FLD_LAT && fld <= FLD_LON_HEMI) begin
      slot = int'(fld - FLD_LAT);
      if (slot % 2 == 1) begin
        // Only the first byte of a hemisphere field decides the sign.
        if (!present[slot]) c_neg[slot / 2] = (ch == CH_S || ch == CH_W);
      end else begin
        coord_char(slot / 2, ch);
      end
      present[slot] = 1'b1;
    end
  endfunction

  function automatic void compare_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    fix_result_t want;
    if (rst) begin
      clear_line_state();
      pos_store[0] = '0;
      pos_store[1] = '0;
      fix_expect_q.delete();
    end else begin
      if (rx.valid && rx.ready) parse_rx_byte(rx.rx_byte);
      if (result.valid && result.ready) begin
        if (fix_expect_q.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          want = fix_expect_q.pop_front();
          compare_field("fix_valid", want.fix, result.fix_valid);
          compare_field("position_updated", want.upd, result.position_updated);
          compare_field("latitude_e7", want.lat, result.latitude_e7);
          compare_field("longitude_e7", want.lon, result.longitude_e7);
        end
      end
    end
    errors  <= fail_count;
    pending <= fix_expect_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the RMC parser testbench: clock, reset, sentence stimulus, result sink and verdict.
`timescale 1ns / 1ps

module tb_top import nrmc_pkg::*;;

  localparam int ITEM_TARGET  = 1700;
  localparam int DRAIN_EVERY  = 25;
  localparam int LONG_HOLD    = 500;
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_LIMIT    = 400000;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] HEMI_CH [4] = '{CH_N, CH_S, CH_E, CH_W};

  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_TOGGLE, RDY_RARE} ready_mode_t;

  logic clk;
  logic rst;
  logic hold_req;

  nrmc_byte_if rx_if ();
  nrmc_fix_if  res_if ();

  int fail_total;
  int pending;
  int cycle_count;
  int bytes_sent;
  int burst_left;
  int line_count;

  ready_mode_t ready_mode;
  int          mode_left;
  int          hold_count;

  logic [7:0] line_buf[$];

  nmea_rmc_position_parser dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if)
  );

  nrmc_fix_checker chk (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_if),
    .result  (res_if),
    .errors  (fail_total),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result sink: one long hold-off once the random traffic starts, then a
  // changing mix of ready patterns.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      ready_mode   <= RDY_ALWAYS;
      mode_left    <= 0;
      hold_count   <= 0;
    end else if (hold_req && hold_count < LONG_HOLD) begin
      res_if.ready <= 1'b0;
      hold_count   <= hold_count + 1;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(16, 160);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        RDY_ALWAYS: res_if.ready <= 1'b1;
        RDY_MOSTLY: res_if.ready <= ($urandom_range(0, 3) != 0);
        RDY_TOGGLE: res_if.ready <= ~res_if.ready;
        default:    res_if.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  function automatic logic [7:0] non_lf_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_LF) ? CH_CR : b;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_digits(input int n);
    for (int i = 0; i < n; i++) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void add_coord();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return;
    if (pick < 3) add_digits($urandom_range(0, 3));
    else if (pick < 5) add_digits($urandom_range(6, 8));
    else add_digits($urandom_range(4, 5));
    if ($urandom_range(0, 4) != 0) begin
      line_buf.push_back(CH_POINT);
      add_digits($urandom_range(0, 8));
    end
    if ($urandom_range(0, 9) == 0) begin
      line_buf.push_back(non_lf_byte());
      add_digits($urandom_range(0, 3));
    end
  endfunction

  function automatic void add_hemi();
    case ($urandom_range(0, 9))
      0: ;
      7: line_buf.push_back(non_lf_byte());
      8: begin
        line_buf.push_back(HEMI_CH[$urandom_range(0, 3)]);
        line_buf.push_back(HEMI_CH[$urandom_range(0, 3)]);
      end
      default: line_buf.push_back(HEMI_CH[$urandom_range(0, 3)]);
    endcase
  endfunction

  // Mostly well-formed RMC lines with random content; the rest are other
  // sentences, damaged prefixes and plain noise.
  function automatic void build_random_line();
    int kind;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 82) begin
      add_text($urandom_range(0, 1) ? "$GPRMC," : "$GNRMC,");
      if ($urandom_range(0, 1)) add_text("123519.00");
      line_buf.push_back(CH_COMMA);
      case ($urandom_range(0, 9))
        0: add_text("V");
        1: ;
        2: add_text("AA");
        3: line_buf.push_back(non_lf_byte());
        default: add_text("A");
      endcase
      line_buf.push_back(CH_COMMA);
      add_coord();
      line_buf.push_back(CH_COMMA);
      add_hemi();
      line_buf.push_back(CH_COMMA);
      add_coord();
      line_buf.push_back(CH_COMMA);
      add_hemi();
      repeat ($urandom_range(0, 8)) begin
        line_buf.push_back(CH_COMMA);
        add_digits($urandom_range(0, 4));
      end
      if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_CR);
      if ($urandom_range(0, 9) == 0)
        line_buf[$urandom_range(0, line_buf.size() - 1)] = non_lf_byte();
    end else if (kind < 92) begin
      if ($urandom_range(0, 1)) begin
        add_text("$GPRMC,,A,4807.1,N,01131.2,E");
        line_buf[$urandom_range(0, 5)] = non_lf_byte();
      end else begin
        add_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08");
      end
    end else begin
      repeat ($urandom_range(0, 30)) line_buf.push_back(non_lf_byte());
    end
    line_buf.push_back(CH_LF);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  task automatic send_text(input string s, input bit cr_tail);
    line_buf.delete();
    add_text(s);
    if (cr_tail) line_buf.push_back(CH_CR);
    line_buf.push_back(CH_LF);
    send_line();
  endtask

  // The checker's count is registered and trails the transfers.
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    hold_req      = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    bytes_sent    = 0;
    burst_left    = 0;
    line_count    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A", 1'b1);
    send_text("$GNRMC,,A,3351.12345,S,15112.98765,W", 1'b0);
    send_text("$GPRMC,,V,4807.038,N,01131.000,E", 1'b0);
    send_text("$GNRMC,,AA,1234.5,N,1234.5,E", 1'b0);
    send_text("$GNRMC,,,4807,N,01131,E", 1'b0);
    send_text("$GNRMC,,A,4807.0,,01131.0,E", 1'b0);
    send_text("$GPRMC,,A,48.,N,123,E", 1'b0);
    send_text("$GPRMC,,A,9999999.99999999,S,99999.99999,W", 1'b0);
    send_text("$GPRMC,,A,9999999.99999999,N,99999.99999,E", 1'b0);
    send_text("$GNRMC,,A,4807.03.5,SN,-01131.5,x", 1'b0);
    send_text("$GNRMC,,A,48 07.5,NS,0113a1.0,w", 1'b0);
    send_text("$GNRMC,1,A,4807.5,N,01131.5,E,1,2,3,4,5,6,7,8,9,10,11,12", 1'b0);
    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08", 1'b0);
    send_text("$GLRMC,,A,1000.0,N,1000.0,E", 1'b0);
    send_text("$GPR", 1'b0);
    send_text("", 1'b0);
    send_text("$GPRMCX,,A,0000.00000,S,0000,W", 1'b0);
    send_text("$GNRMC,,A,.,N,0.5,E", 1'b0);
    send_text("$GNRMC,,a,4807,N,01131,E", 1'b0);
    send_text("$GNRMC,,A", 1'b1);

    // Bytes at both ends of the range inside the coordinate fields.
    line_buf.delete();
    add_text("$GNRMC,,A,");
    line_buf.push_back(8'hFF);
    add_text("4807,N,0113");
    line_buf.push_back(8'h00);
    add_text("1,E");
    line_buf.push_back(8'h7F);
    line_buf.push_back(CH_LF);
    send_line();

    hold_req <= 1'b1;
    while (bytes_sent < ITEM_TARGET) begin
      build_random_line();
      send_line();
      line_count++;
      if (line_count % DRAIN_EVERY == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_total == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/nrmc_pkg.sv
sv/nrmc_if.sv
sv/nrmc_coord.sv
sv/nmea_rmc_position_parser.sv
bench/nrmc_fix_checker.sv
bench/tb_top.sv
